[sv/sqltl_pkg.sv]
`default_nettype none
package sqltl_pkg;

	typedef enum logic [2:0] {
		MODE_IDLE  = 3'd0,
		MODE_IDENT = 3'd1,
		MODE_NUM   = 3'd2,
		MODE_STR   = 3'd3,
		MODE_ESC   = 3'd4,
		MODE_ERR   = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		EV_BYTE    = 2'd0,
		EV_CLOSE   = 2'd1,
		EV_UNTERM  = 2'd2,
		EV_BADCHAR = 2'd3
	} ev_t;

	localparam logic [3:0] TT_IDENT = 4'd0;
	localparam logic [3:0] TT_NUM   = 4'd1;
	localparam logic [3:0] TT_STR   = 4'd2;
	localparam logic [3:0] TT_COMMA = 4'd3;
	localparam logic [3:0] TT_SEMI  = 4'd4;
	localparam logic [3:0] TT_LPAR  = 4'd5;
	localparam logic [3:0] TT_RPAR  = 4'd6;
	localparam logic [3:0] TT_STAR  = 4'd7;
	localparam logic [3:0] TT_EQ    = 4'd8;
	localparam logic [3:0] TT_GT    = 4'd9;
	localparam logic [3:0] TT_LT    = 4'd10;
	localparam logic [3:0] TT_END   = 4'd11;

	localparam logic KIND_TEXT = 1'b0;
	localparam logic KIND_EOI  = 1'b1;

	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	typedef struct packed {
		ev_t        ev;
		logic [3:0] ty;
		logic [7:0] data;
	} result_t;

	// up to three results caused by one request; cnt is never zero in the queue
	typedef struct packed {
		logic [1:0]   cnt;
		result_t [2:0] res;
	} plan_t;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic [3:0] punct_type(input logic [7:0] c);
		logic [3:0] t;
		unique case (c)
			8'h2C: t = TT_COMMA;
			8'h3B: t = TT_SEMI;
			8'h28: t = TT_LPAR;
			8'h29: t = TT_RPAR;
			8'h2A: t = TT_STAR;
			8'h3D: t = TT_EQ;
			8'h3E: t = TT_GT;
			8'h3C: t = TT_LT;
			default: t = TT_IDENT;
		endcase
		return t;
	endfunction

endpackage
`default_nettype wire

[sv/sqltl_in_if.sv]
`default_nettype none
interface sqltl_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] in_byte;

	modport source (output valid, kind, in_byte, input ready);
	modport sink   (input valid, kind, in_byte, output ready);
endinterface
`default_nettype wire

[sv/sqltl_out_if.sv]
`default_nettype none
interface sqltl_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] event_res;
	logic [3:0] token_type;
	logic [7:0] token_byte;
	logic       last;

	modport source (output valid, event_res, token_type, token_byte, last, input ready);
	modport sink   (input valid, event_res, token_type, token_byte, last, output ready);
endinterface
`default_nettype wire

[sv/sqltl_front.sv]
`default_nettype none
module sqltl_front
	import sqltl_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       fire,
	input  wire logic       kind,
	input  wire logic [7:0] in_byte,
	output plan_t           plan,
	output logic            plan_valid
);

	typedef struct packed {
		mode_t      mode;
		logic [1:0] cnt;
		result_t    r0;
		result_t    r1;
	} start_t;

	mode_t mode_q;
	mode_t mode_d;

	function automatic result_t mk(input ev_t ev, input logic [3:0] ty, input logic [7:0] d);
		result_t r;
		r.ev   = ev;
		r.ty   = ty;
		r.data = d;
		return r;
	endfunction

	// handling of a byte seen in idle mode
	function automatic start_t start_byte(input logic [7:0] c);
		start_t s;
		logic [3:0] p;
		p      = punct_type(c);
		s.mode = MODE_IDLE;
		s.cnt  = 2'd0;
		s.r0   = '0;
		s.r1   = '0;
		priority if (is_space(c)) begin
			s.cnt = 2'd0;
		end else if (is_letter(c) || c == CH_UNDER) begin
			s.mode = MODE_IDENT;
			s.cnt  = 2'd1;
			s.r0   = mk(EV_BYTE, TT_IDENT, c);
		end else if (is_digit(c) || c == CH_MINUS) begin
			s.mode = MODE_NUM;
			s.cnt  = 2'd1;
			s.r0   = mk(EV_BYTE, TT_NUM, c);
		end else if (c == CH_QUOTE) begin
			s.mode = MODE_STR;
		end else if (p != TT_IDENT) begin
			s.cnt = 2'd2;
			s.r0  = mk(EV_BYTE, p, c);
			s.r1  = mk(EV_CLOSE, p, 8'd0);
		end else begin
			s.mode = MODE_ERR;
			s.cnt  = 2'd1;
			s.r0   = mk(EV_BADCHAR, TT_IDENT, 8'd0);
		end
		return s;
	endfunction

	start_t  st;
	logic    do_start;
	logic    close_v;
	result_t close_r;
	logic [1:0] cnt;
	result_t r0, r1, r2;

	always_comb begin
		st       = start_byte(in_byte);
		mode_d   = mode_q;
		do_start = 1'b0;
		close_v  = 1'b0;
		close_r  = '0;
		cnt      = 2'd0;
		r0       = '0;
		r1       = '0;
		r2       = '0;
		if (kind == KIND_EOI) begin
			mode_d = MODE_IDLE;
			unique case (mode_q)
				MODE_IDLE: begin
					cnt = 2'd1;
					r0  = mk(EV_CLOSE, TT_END, 8'd0);
				end
				MODE_IDENT, MODE_NUM: begin
					cnt = 2'd2;
					r0  = mk(EV_CLOSE, (mode_q == MODE_IDENT) ? TT_IDENT : TT_NUM, 8'd0);
					r1  = mk(EV_CLOSE, TT_END, 8'd0);
				end
				MODE_STR, MODE_ESC: begin
					cnt = 2'd1;
					r0  = mk(EV_UNTERM, TT_IDENT, 8'd0);
				end
				default: cnt = 2'd0;
			endcase
		end else begin
			unique case (mode_q)
				MODE_IDLE: do_start = 1'b1;
				MODE_IDENT: begin
					if (is_letter(in_byte) || is_digit(in_byte) || in_byte == CH_UNDER
							|| in_byte == CH_DOT) begin
						cnt = 2'd1;
						r0  = mk(EV_BYTE, TT_IDENT, in_byte);
					end else begin
						close_v  = 1'b1;
						close_r  = mk(EV_CLOSE, TT_IDENT, 8'd0);
						do_start = 1'b1;
					end
				end
				MODE_NUM: begin
					if (is_digit(in_byte) || in_byte == CH_DOT) begin
						cnt = 2'd1;
						r0  = mk(EV_BYTE, TT_NUM, in_byte);
					end else begin
						close_v  = 1'b1;
						close_r  = mk(EV_CLOSE, TT_NUM, 8'd0);
						do_start = 1'b1;
					end
				end
				MODE_STR: begin
					if (in_byte == CH_QUOTE) begin
						cnt    = 2'd1;
						r0     = mk(EV_CLOSE, TT_STR, 8'd0);
						mode_d = MODE_IDLE;
					end else if (in_byte == CH_BSLASH) begin
						mode_d = MODE_ESC;
					end else begin
						cnt = 2'd1;
						r0  = mk(EV_BYTE, TT_STR, in_byte);
					end
				end
				MODE_ESC: begin
					cnt    = 2'd1;
					r0     = mk(EV_BYTE, TT_STR, in_byte);
					mode_d = MODE_STR;
				end
				default: cnt = 2'd0;
			endcase
			if (do_start) begin
				mode_d = st.mode;
				cnt    = st.cnt + {1'b0, close_v};
				r0     = close_v ? close_r : st.r0;
				r1     = close_v ? st.r0 : st.r1;
				r2     = st.r1;
			end
		end
	end

	assign plan.cnt    = cnt;
	assign plan.res[0] = r0;
	assign plan.res[1] = r1;
	assign plan.res[2] = r2;
	assign plan_valid  = fire && (cnt != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
		end else if (fire) begin
			mode_q <= mode_d;
		end
	end

endmodule
`default_nettype wire

[sv/sqltl_queue.sv]
`default_nettype none
module sqltl_queue
	import sqltl_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  plan_t      push_plan,
	output logic       full,
	input  wire logic  pop,
	output plan_t      head,
	output logic       empty
);

	plan_t          mem_q [QDEPTH];
	logic [QAW-1:0] wr_q;
	logic [QAW-1:0] rd_q;
	logic [QAW:0]   count_q;

	assign full  = (count_q == (QAW+1)'(QDEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_plan;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

[sv/sqltl_back.sv]
`default_nettype none
module sqltl_back
	import sqltl_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  plan_t      head,
	input  wire logic  empty,
	output logic       pop,
	sqltl_out_if.source out_ch
);

	logic [1:0] idx_q;
	logic       valid_q;
	result_t    res_q;
	logic       last_q;
	logic       load;
	logic       is_last;

	assign load    = !empty && (!valid_q || out_ch.ready);
	assign is_last = (idx_q == head.cnt - 2'd1);
	assign pop     = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= is_last ? 2'd0 : idx_q + 2'd1;
			end else if (out_ch.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q  <= head.res[idx_q];
			last_q <= is_last;
		end
	end

	assign out_ch.valid      = valid_q;
	assign out_ch.event_res  = res_q.ev;
	assign out_ch.token_type = res_q.ty;
	assign out_ch.token_byte = res_q.data;
	assign out_ch.last       = last_q;

endmodule
`default_nettype wire

[sv/sql_token_lexer.sv]
`default_nettype none
// channel  dir  payload                                   accept
// in_ch    in   kind, in_byte                             valid && ready
// out_ch   out  event_res, token_type, token_byte, last   valid && ready
//
// A request is classified in the cycle it is accepted. The single output register
// drains the plan queue one result at a time, up to three results per request.
// The four-entry plan queue lets input keep flowing while output stalls, until it fills.
// Reset returns the lexer to idle and empties the queue; no clearing pass.
module sql_token_lexer
	import sqltl_pkg::*;
(
	input wire logic    clk,
	input wire logic    arst_n,
	sqltl_in_if.sink    in_ch,
	sqltl_out_if.source out_ch
);

	plan_t plan;
	logic  plan_valid;
	logic  full;
	logic  fire;
	plan_t head;
	logic  empty;
	logic  pop;

	assign in_ch.ready = !full;
	assign fire        = in_ch.valid && !full;

	sqltl_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.kind       (in_ch.kind),
		.in_byte    (in_ch.in_byte),
		.plan       (plan),
		.plan_valid (plan_valid)
	);

	sqltl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (plan_valid),
		.push_plan (plan),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	sqltl_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (empty),
		.pop    (pop),
		.out_ch (out_ch)
	);

endmodule
`default_nettype wire
